// ----- design/sfp_pkg.sv -----
// shared types and constants of the star field plotter
`default_nettype none
package sfp_pkg;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_X        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIP_Y        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BASE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_MASK   = 3'd7;

	// plot modes
	localparam logic [2:0] MODE_SCROLL      = 3'd0;
	localparam logic [2:0] MODE_SCROLL_MASK = 3'd1;
	localparam logic [2:0] MODE_BLINK       = 3'd2;
	localparam logic [2:0] MODE_BLINK_HALFY = 3'd3;
	localparam logic [2:0] MODE_BLINK_LEFT  = 3'd4;

	// blink phases
	localparam logic [1:0] PHASE_COLOUR0 = 2'd0;
	localparam logic [1:0] PHASE_COLOUR2 = 2'd1;
	localparam logic [1:0] PHASE_LINE1   = 2'd2;
	localparam logic [1:0] PHASE_ALL     = 2'd3;

	// function codes
	localparam logic FUNC_FRAME = 1'b0;
	localparam logic FUNC_STAR  = 1'b1;

	localparam logic [7:0]  Y_OFFSET      = 8'd16;
	localparam logic [7:0]  HALFY_X_LIMIT = 8'd240;
	localparam logic [7:0]  FRAMES_MAX    = 8'd255;
	localparam logic [16:0] SCROLL_RESET  = 17'h1ffff;

	typedef struct packed {
		logic [2:0]  mode;
		logic        flip_x;
		logic        flip_y;
		logic [8:0]  screen_width;
		logic [8:0]  screen_height;
		logic [8:0]  palette_base;
		logic [7:0]  blink_period;
		logic [31:0] column_mask;
	} cfg_t;

	typedef struct packed {
		logic [16:0] scroll;
		logic [1:0]  phase;
	} frame_t;

	typedef struct packed {
		logic       func;
		logic [8:0] star_x;
		logic [7:0] star_y;
		logic [5:0] star_colour;
	} star_t;

	typedef struct packed {
		logic       plot;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic [8:0] pen;
	} result_t;

	function automatic logic is_scroll(input logic [2:0] m);
		return (m == MODE_SCROLL) || (m == MODE_SCROLL_MASK);
	endfunction

	function automatic logic is_blink(input logic [2:0] m);
		return (m == MODE_BLINK) || (m == MODE_BLINK_HALFY) || (m == MODE_BLINK_LEFT);
	endfunction

endpackage
`default_nettype wire

// ----- design/sfp_cfg_regs.sv -----
// configuration register file of the star field plotter
`default_nettype none
module sfp_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sfp_pkg::cfg_t                        cfg
);
	import sfp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= MODE_SCROLL;
			cfg_q.flip_x        <= 1'b0;
			cfg_q.flip_y        <= 1'b0;
			cfg_q.screen_width  <= 9'd256;
			cfg_q.screen_height <= 9'd224;
			cfg_q.palette_base  <= 9'd0;
			cfg_q.blink_period  <= 8'd46;
			cfg_q.column_mask   <= 32'hffff_ffff;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:          cfg_q.mode          <= cfg_data[2:0];
				CFG_FLIP_X:        cfg_q.flip_x        <= cfg_data[0];
				CFG_FLIP_Y:        cfg_q.flip_y        <= cfg_data[0];
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[8:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[8:0];
				CFG_PALETTE_BASE:  cfg_q.palette_base  <= cfg_data[8:0];
				CFG_BLINK_PERIOD:  cfg_q.blink_period  <= cfg_data[7:0];
				CFG_COLUMN_MASK:   cfg_q.column_mask   <= cfg_data[31:0];
				default:           cfg_q.mode          <= cfg_q.mode;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- design/sfp_frame_state.sv -----
// per-frame scroll position and blink phase
`default_nettype none
module sfp_frame_state (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        frame_step,
	input  wire logic [2:0]  mode,
	input  wire logic [7:0]  blink_period,
	output sfp_pkg::frame_t  frame
);
	import sfp_pkg::*;

	logic [16:0] scroll_q;
	logic [1:0]  phase_q;
	logic [7:0]  frames_q;
	logic [7:0]  frames_inc;

	// saturating frame count
	assign frames_inc = (frames_q < FRAMES_MAX) ? frames_q + 8'd1 : frames_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_q <= SCROLL_RESET;
			phase_q  <= PHASE_COLOUR0;
			frames_q <= 8'd0;
		end else if (frame_step) begin
			if (is_scroll(mode)) begin
				scroll_q <= scroll_q + 17'd1;
			end else if (is_blink(mode)) begin
				if (frames_inc >= blink_period) begin
					frames_q <= 8'd0;
					phase_q  <= phase_q + 2'd1;
				end else begin
					frames_q <= frames_inc;
				end
			end
		end
	end

	assign frame.scroll = scroll_q;
	assign frame.phase  = phase_q;

endmodule
`default_nettype wire

// ----- design/sfp_star_calc.sv -----
// plot decision and pixel position for one star record
`default_nettype none
module sfp_star_calc (
	input  wire sfp_pkg::star_t   star,
	input  wire sfp_pkg::cfg_t    cfg,
	input  wire sfp_pkg::frame_t  frame,
	output sfp_pkg::result_t      res
);
	import sfp_pkg::*;

	logic [16:0] pos;
	logic [7:0]  x_raw;
	logic [7:0]  y_raw;
	logic [7:0]  x_fl;
	logic [7:0]  y_fl;
	logic [4:0]  col_grp;
	logic        vis;
	logic        blink_ok;
	logic        mode_ok;
	logic        mask_ok;
	logic        bounds_ok;
	logic [7:0]  y_off;

	assign pos = frame.scroll + {8'd0, star.star_x};

	always_comb begin
		unique case (frame.phase)
			PHASE_COLOUR0: blink_ok = star.star_colour[0];
			PHASE_COLOUR2: blink_ok = star.star_colour[2];
			PHASE_LINE1:   blink_ok = star.star_y[1];
			PHASE_ALL:     blink_ok = 1'b1;
			default:       blink_ok = 1'b1;
		endcase
	end

	always_comb begin
		if (is_scroll(cfg.mode)) begin
			x_raw   = pos[8:1];
			y_raw   = star.star_y + pos[16:9];
			vis     = y_raw[0] ^ x_raw[3];
			mode_ok = 1'b1;
		end else begin
			x_raw = star.star_x[8:1];
			y_raw = star.star_y;
			// half-y mode checks the checkerboard on every second line
			vis   = ((cfg.mode == MODE_BLINK_HALFY) ? star.star_y[1] : star.star_y[0])
				^ x_raw[3];
			mode_ok = is_blink(cfg.mode) && blink_ok
				&& !((cfg.mode == MODE_BLINK_LEFT) && x_raw[7])
				&& !((cfg.mode == MODE_BLINK_HALFY) && (x_raw >= HALFY_X_LIMIT));
		end
	end

	assign x_fl    = cfg.flip_x ? ~x_raw : x_raw;
	assign y_fl    = cfg.flip_y ? ~y_raw : y_raw;
	assign y_off   = y_fl - Y_OFFSET;
	assign col_grp = x_fl[7:3] + 5'd1;
	assign mask_ok = (cfg.mode != MODE_SCROLL_MASK) || cfg.column_mask[col_grp];

	assign bounds_ok = (y_fl >= Y_OFFSET)
		&& ({1'b0, y_off} < cfg.screen_height)
		&& ({1'b0, x_fl} < cfg.screen_width);

	assign res.plot    = vis && mode_ok && mask_ok && bounds_ok;
	assign res.pixel_x = x_fl;
	assign res.pixel_y = y_off;
	assign res.pen     = cfg.palette_base + {3'd0, star.star_colour};

endmodule
`default_nettype wire

// ----- design/star_field_plotter.sv -----
// top level of the star field plotter
`default_nettype none
// Star field plotter. Each input transfer is either a begin-frame item
// (s_tuser low) or one star record (s_tuser high). A star is registered on
// entry, evaluated by one level of logic against the configuration and the
// frame state, and its pixel lands in the output register when the output
// advances; one item is taken every cycle while the output is drained, and a
// stalled output holds the input stage after one more item. A begin frame
// updates the scroll position or blink phase as it leaves the input stage and
// gives no output transfer; stars that follow see the new state. Stars that
// are not plotted give no output transfer either.
// Configuration writes take effect at once and belong in idle periods.
module star_field_plotter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// star_x[8:0], star_y[16:9], star_colour[22:17], zero fill
	input  wire logic [sfp_pkg::IN_DATA_W-1:0]     s_tdata,
	// func: 0 begin frame, 1 star record
	input  wire logic                              s_tuser,
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// pixel_x[7:0], pixel_y[15:8], pen[24:16], zero fill
	output      logic [sfp_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [sfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sfp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sfp_pkg::*;

	cfg_t    cfg;
	frame_t  frame;
	result_t res;
	star_t   star_s1;
	logic    valid_s1;
	logic    m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic    advance;
	logic    frame_step;

	assign advance    = !m_tvalid_q || m_tready;
	assign s_tready   = !valid_s1 || advance;
	assign frame_step = valid_s1 && advance && (star_s1.func == FUNC_FRAME);

	sfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfp_frame_state u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_step   (frame_step),
		.mode         (cfg.mode),
		.blink_period (cfg.blink_period),
		.frame        (frame)
	);

	sfp_star_calc u_calc (
		.star  (star_s1),
		.cfg   (cfg),
		.frame (frame),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			star_s1.func        <= s_tuser;
			star_s1.star_x      <= s_tdata[8:0];
			star_s1.star_y      <= s_tdata[16:9];
			star_s1.star_colour <= s_tdata[22:17];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1 && (star_s1.func == FUNC_STAR) && res.plot;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {7'd0, res.pen, res.pixel_y, res.pixel_x};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

// ----- design/sfp_checker.sv -----
// port-level checks of the star field plotter
`default_nettype none
module sfp_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [sfp_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import sfp_pkg::*;

	// a stalled output transfer holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// the line offset keeps every plotted line below 240
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:12] != 4'hf)
		else $error("pixel line beyond offset range");

	// an empty output register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a draining output keeps the input open
	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// padding bits above the pen stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:25] == 7'd0)
		else $error("output padding not zero");

endmodule

bind star_field_plotter sfp_checker u_sfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/star_field_plotter_tb.sv -----
// testbench for the star field plotter: directed and random items checked by a built-in predictor
module star_field_plotter_tb;
	import sfp_pkg::*;

	// modes that the block must ignore
	localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
	localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

	typedef struct packed {
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic [8:0] pen;
	} pixel_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int unsigned send_idle_pct     = 0;
	int unsigned receive_stall_pct = 0;
	int unsigned error_count       = 0;

	// predictor copy of the configuration and the frame state
	cfg_t plot_cfg = '{MODE_SCROLL, 1'b0, 1'b0, 9'd256, 9'd224, 9'd0, 8'd46, 32'hffff_ffff};
	logic [16:0] scroll_pos  = SCROLL_RESET;
	logic [1:0]  blink_phase = PHASE_COLOUR0;
	logic [7:0]  frames_seen = '0;

	pixel_t expected_pixels[$];

	star_field_plotter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receive_stall_pct);
	end

	task automatic note_error(input string what);
		error_count++;
		if (error_count <= 10)
			$display("%s", what);
	endtask

	function automatic void advance_frame();
		if (plot_cfg.mode == MODE_SCROLL || plot_cfg.mode == MODE_SCROLL_MASK) begin
			scroll_pos = scroll_pos + 17'd1;
		end else if (plot_cfg.mode <= MODE_BLINK_LEFT) begin
			if (frames_seen < FRAMES_MAX)
				frames_seen = frames_seen + 8'd1;
			if (frames_seen >= plot_cfg.blink_period) begin
				frames_seen = '0;
				blink_phase = blink_phase + 2'd1;
			end
		end
	endfunction

	function automatic bit plot_star(input logic [8:0] sx, input logic [7:0] sy,
			input logic [5:0] colour, output pixel_t pix);
		logic [16:0] pos;
		logic [7:0]  px;
		logic [7:0]  py;
		logic [7:0]  check_y;
		logic [4:0]  group;
		int          line;
		bit          shown;
		pix = '0;
		if (plot_cfg.mode > MODE_BLINK_LEFT)
			return 1'b0;
		if (plot_cfg.mode == MODE_SCROLL || plot_cfg.mode == MODE_SCROLL_MASK) begin
			pos = scroll_pos + {8'd0, sx};
			px = pos[8:1];
			py = sy + pos[16:9];
			// checkerboard: line parity against the 8-pixel column group
			if (py[0] == px[3])
				return 1'b0;
		end else begin
			px = sx[8:1];
			check_y = (plot_cfg.mode == MODE_BLINK_HALFY) ? {1'b0, sy[7:1]} : sy;
			if (check_y[0] == px[3])
				return 1'b0;
			if (plot_cfg.mode == MODE_BLINK_LEFT && px[7])
				return 1'b0;
			case (blink_phase)
				PHASE_COLOUR0: shown = colour[0];
				PHASE_COLOUR2: shown = colour[2];
				PHASE_LINE1:   shown = sy[1];
				default:       shown = 1'b1;
			endcase
			if (!shown)
				return 1'b0;
			if (plot_cfg.mode == MODE_BLINK_HALFY && px >= HALFY_X_LIMIT)
				return 1'b0;
			py = sy;
		end
		if (plot_cfg.flip_x)
			px = ~px;
		if (plot_cfg.flip_y)
			py = ~py;
		line = int'(py) - int'(Y_OFFSET);
		group = px[7:3] + 5'd1;
		if (plot_cfg.mode == MODE_SCROLL_MASK && !plot_cfg.column_mask[group])
			return 1'b0;
		if (line < 0 || line >= int'(plot_cfg.screen_height) ||
				{1'b0, px} >= plot_cfg.screen_width)
			return 1'b0;
		pix.pixel_x = px;
		pix.pixel_y = line[7:0];
		pix.pen = plot_cfg.palette_base + {3'd0, colour};
		return 1'b1;
	endfunction

	task automatic send_item(input logic func, input logic [8:0] sx, input logic [7:0] sy,
			input logic [5:0] colour);
		pixel_t pix;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {1'b0, colour, sy, sx};
		do @(posedge clk); while (!s_tready);
		if (func == FUNC_FRAME)
			advance_frame();
		else if (plot_star(sx, sy, colour, pix))
			expected_pixels.push_back(pix);
	endtask

	// stars that are not plotted may still be in the pipe when the queue runs empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		for (int n = 0; n < 100000 && expected_pixels.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			note_error($sformatf("%0d expected pixels never arrived", expected_pixels.size()));
			expected_pixels.delete();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			CFG_MODE:          plot_cfg.mode = value[2:0];
			CFG_FLIP_X:        plot_cfg.flip_x = value[0];
			CFG_FLIP_Y:        plot_cfg.flip_y = value[0];
			CFG_SCREEN_WIDTH:  plot_cfg.screen_width = value[8:0];
			CFG_SCREEN_HEIGHT: plot_cfg.screen_height = value[8:0];
			CFG_PALETTE_BASE:  plot_cfg.palette_base = value[8:0];
			CFG_BLINK_PERIOD:  plot_cfg.blink_period = value[7:0];
			default:           plot_cfg.column_mask = value;
		endcase
	endtask

	function automatic logic [8:0] pick_size();
		case ($urandom_range(9))
			0:          return 9'd0;
			1:          return 9'd1;
			2, 3, 4, 5: return 9'd256;
			6:          return 9'($urandom_range(511, 257));
			default:    return 9'($urandom_range(255, 2));
		endcase
	endfunction

	// unused upper bits of each write but the column mask carry random junk
	task automatic apply_random_config();
		logic [2:0]  mode;
		logic [8:0]  base;
		logic [7:0]  period;
		logic [31:0] mask;
		if ($urandom_range(9) == 0)
			mode = 3'($urandom_range(MODE_UNDEF_HI, MODE_UNDEF_LO));
		else
			mode = 3'($urandom_range(MODE_BLINK_LEFT, MODE_SCROLL));
		case ($urandom_range(4))
			0:       base = 9'd0;
			1:       base = 9'd511;
			2:       base = 9'd448;
			default: base = 9'($urandom_range(511));
		endcase
		case ($urandom_range(7))
			0:       period = 8'd0;
			1:       period = 8'd255;
			default: period = 8'($urandom_range(6, 1));
		endcase
		case ($urandom_range(5))
			0:       mask = 32'hffff_ffff;
			1:       mask = 32'h0;
			default: mask = $urandom();
		endcase
		write_reg(CFG_MODE, 32'({$urandom(), mode}));
		write_reg(CFG_FLIP_X, $urandom());
		write_reg(CFG_FLIP_Y, $urandom());
		write_reg(CFG_SCREEN_WIDTH, 32'({$urandom(), pick_size()}));
		write_reg(CFG_SCREEN_HEIGHT, 32'({$urandom(), pick_size()}));
		write_reg(CFG_PALETTE_BASE, 32'({$urandom(), base}));
		write_reg(CFG_BLINK_PERIOD, 32'({$urandom(), period}));
		write_reg(CFG_COLUMN_MASK, mask);
	endtask

	task automatic send_random_items(input int unsigned count);
		logic func;
		repeat (count) begin
			func = ($urandom_range(7) == 0) ? FUNC_FRAME : FUNC_STAR;
			send_item(func, 9'($urandom_range(511)), 8'($urandom_range(255)),
				6'($urandom_range(63)));
		end
	endtask

	task automatic test_scroll_directed();
		// reset settings, scroll position one step before wrapping
		send_item(FUNC_STAR, 9'd0, 8'd0, 6'd0);
		send_item(FUNC_STAR, 9'd511, 8'd255, 6'd63);
		send_item(FUNC_FRAME, 9'd0, 8'd0, 6'd0);
		send_item(FUNC_STAR, 9'd511, 8'd255, 6'd63);
		send_item(FUNC_STAR, 9'd17, 8'd40, 6'd21);
		wait_drained();
		write_reg(CFG_MODE, 32'(MODE_SCROLL_MASK));
		write_reg(CFG_COLUMN_MASK, 32'haaaa_aaaa);
		write_reg(CFG_PALETTE_BASE, 32'd511);
		write_reg(CFG_FLIP_X, 32'd1);
		write_reg(CFG_FLIP_Y, 32'd1);
		send_item(FUNC_STAR, 9'd0, 8'd255, 6'd63);
		send_item(FUNC_STAR, 9'd30, 8'd17, 6'd1);
		send_item(FUNC_FRAME, 9'd511, 8'd255, 6'd63);
		send_item(FUNC_STAR, 9'd32, 8'd100, 6'd42);
		wait_drained();
	endtask

	task automatic test_blink_directed();
		write_reg(CFG_FLIP_X, 32'd0);
		write_reg(CFG_FLIP_Y, 32'd0);
		write_reg(CFG_PALETTE_BASE, 32'd448);
		write_reg(CFG_MODE, 32'(MODE_BLINK));
		// a zero period steps the phase on every frame
		write_reg(CFG_BLINK_PERIOD, 32'd0);
		for (int i = 0; i < 4; i++) begin
			send_item(FUNC_FRAME, 9'd0, 8'd0, 6'd0);
			send_item(FUNC_STAR, 9'd16, 8'd34, 6'(i * 5));
		end
		wait_drained();
	endtask

	task automatic test_bounds_directed();
		write_reg(CFG_MODE, 32'(MODE_BLINK_HALFY));
		write_reg(CFG_SCREEN_WIDTH, 32'd300);
		send_item(FUNC_STAR, 9'd500, 8'd37, 6'h3f);
		send_item(FUNC_STAR, 9'd0, 8'd10, 6'h3f);
		wait_drained();
		write_reg(CFG_MODE, 32'(MODE_BLINK_LEFT));
		send_item(FUNC_STAR, 9'd300, 8'd35, 6'h3f);
		wait_drained();
		write_reg(CFG_MODE, 32'(MODE_UNDEF_HI));
		send_item(FUNC_FRAME, 9'd0, 8'd0, 6'd0);
		send_item(FUNC_STAR, 9'd16, 8'd34, 6'h3f);
		wait_drained();
		// back to scrolling: frames in blink and undefined modes must not have moved the scroll position
		write_reg(CFG_MODE, 32'(MODE_SCROLL));
		write_reg(CFG_SCREEN_HEIGHT, 32'd0);
		send_item(FUNC_STAR, 9'd16, 8'd35, 6'h2a);
		wait_drained();
		write_reg(CFG_SCREEN_HEIGHT, 32'd511);
		send_item(FUNC_STAR, 9'd16, 8'd254, 6'h15);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
		int unsigned counted;
		counted = 0;
		send_idle_pct = idle_pct;
		receive_stall_pct = stall_pct;
		while (counted < 260) begin
			apply_random_config();
			if (plot_cfg.mode > MODE_BLINK_LEFT) begin
				send_random_items(16);
			end else begin
				send_random_items(65);
				counted += 65;
			end
			wait_drained();
		end
	endtask

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				note_error($sformatf("unexpected pixel x=%0d y=%0d pen=%0d",
					m_tdata[7:0], m_tdata[15:8], m_tdata[24:16]));
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata[7:0] !== want.pixel_x || m_tdata[15:8] !== want.pixel_y ||
						m_tdata[24:16] !== want.pen || m_tdata[31:25] !== 7'd0)
					note_error($sformatf(
						"pixel mismatch: expected x=%0d y=%0d pen=%0d, got x=%0d y=%0d pen=%0d fill=%h",
						want.pixel_x, want.pixel_y, want.pen,
						m_tdata[7:0], m_tdata[15:8], m_tdata[24:16], m_tdata[31:25]));
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_scroll_directed();
		test_blink_directed();
		test_bounds_directed();
		test_random_traffic(0, 0);
		test_random_traffic(80, 0);
		test_random_traffic(0, 80);
		test_random_traffic(23, 23);
		if (error_count == 0)
			$display("star_field_plotter_tb: clean");
		else
			$display("star_field_plotter_tb: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("star_field_plotter_tb: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
design/sfp_pkg.sv
design/sfp_cfg_regs.sv
design/sfp_frame_state.sv
design/sfp_star_calc.sv
design/star_field_plotter.sv
design/sfp_checker.sv
test/star_field_plotter_tb.sv
